FILE: src/assert_macros.svh
// concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

FILE: src/spat_pkg.sv
`default_nettype none
package spat_pkg;

  localparam int DESC_DEPTH = 64;
  localparam int DESC_AW    = $clog2(DESC_DEPTH);
  localparam int DIR_DEPTH  = 1024;
  localparam int DIR_AW     = 10;
  localparam int CNT_W      = 7;
  localparam int SEL_W      = 14;
  localparam logic [SEL_W-1:0] DESC_DEPTH_C = SEL_W'(DESC_DEPTH);

  localparam logic [2:0] OP_TRANSLATE = 3'd0;
  localparam logic [2:0] OP_WR_GLOBAL = 3'd1;
  localparam logic [2:0] OP_WR_LOCAL  = 3'd2;
  localparam logic [2:0] OP_WR_DIR    = 3'd3;
  localparam logic [2:0] OP_WR_PAGE   = 3'd4;

  localparam logic [2:0] FAULT_OK     = 3'd0;
  localparam logic [2:0] FAULT_SEL    = 3'd1;
  localparam logic [2:0] FAULT_SEG    = 3'd2;
  localparam logic [2:0] FAULT_LIMIT  = 3'd3;
  localparam logic [2:0] FAULT_PAGE   = 3'd4;

  localparam logic REG_GLOBAL_COUNT = 1'b0;
  localparam logic REG_LOCAL_COUNT  = 1'b1;

  typedef enum logic [2:0] {
    K_TRANSLATE,
    K_WR_GLOBAL,
    K_WR_LOCAL,
    K_WR_DIR,
    K_WR_PAGE,
    K_NULL,
    K_SEL_FAULT
  } cmd_kind_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [9:0]  entry_index;
    logic [63:0] entry_data;
    logic [31:0] logical_offset;
    logic [15:0] segment_selector;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  fault_code;
    logic [31:0] lin_addr;
    logic [31:0] physical_address;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic               is_local;
    logic [DESC_AW-1:0] desc_addr;
    logic [DIR_AW-1:0]  entry_index;
    logic [63:0]        entry_data;
    logic [31:0]        logical_offset;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage
`default_nettype wire

FILE: src/segment_page_address_translator_unit.sv
// segment and page address translator. each transaction carries an opcode: writes fill the
// global or local descriptor table, the page directory present bits or the shared page
// table, and a translate checks the selector, the segment present bit and limit and then
// the directory and page table entries, returning linear and physical addresses or a
// fault code. every transaction gives exactly one result, in order. a write or an early
// selector fault is answered from idle, a segment or limit fault after the descriptor ram
// read, and a translation that reaches the page lookup passes the descriptor ram read, then
// the directory and page table ram reads addressed by the linear address, then the output
// register. after reset a clearing pass zeroes all 1024 directory and page table entries,
// during which in_stall is high; configuration writes are taken at any time.
`default_nettype none
module segment_page_address_translator_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input transactions
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire spat_pkg::in_item_t  in_item,
  // results
  output logic                     out_valid,
  input  wire logic                out_stall,
  output spat_pkg::out_item_t      out_item,
  // configuration
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic [spat_pkg::CNT_W-1:0] global_count_r, global_count_nxt;
  logic [spat_pkg::CNT_W-1:0] local_count_r, local_count_nxt;
  logic                       cfg_wr;

  spat_pkg::q_status_t q_status;
  spat_pkg::cmd_t      push_cmd, head;
  logic                push, pop, busy;

  // register file: index is address bit 2
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    global_count_nxt = global_count_r;
    local_count_nxt  = local_count_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        spat_pkg::REG_GLOBAL_COUNT: global_count_nxt = pwdata[spat_pkg::CNT_W-1:0];
        spat_pkg::REG_LOCAL_COUNT:  local_count_nxt  = pwdata[spat_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      global_count_r <= '0;
      local_count_r  <= '0;
    end else begin
      global_count_r <= global_count_nxt;
      local_count_r  <= local_count_nxt;
    end
  end

  assign prdata = 32'((paddr[2] == spat_pkg::REG_LOCAL_COUNT) ? local_count_r : global_count_r);

  // front: accept and classify, selector checks happen here
  spat_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_item      (in_item),
    .global_count (global_count_r),
    .local_count  (local_count_r),
    .busy         (busy),
    .q_status     (q_status),
    .push         (push),
    .cmd          (push_cmd)
  );

  // two-entry command queue decouples front from back
  spat_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // back: table rams, translation sequencer and output register
  spat_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .head      (head),
    .pop       (pop),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

FILE: src/spat_ram.sv
`default_nettype none
module spat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: src/spat_front.sv
`default_nettype none
module spat_front (
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire spat_pkg::in_item_t        in_item,
  input  wire logic [spat_pkg::CNT_W-1:0] global_count,
  input  wire logic [spat_pkg::CNT_W-1:0] local_count,
  input  wire logic                      busy,
  input  wire spat_pkg::q_status_t       q_status,
  output logic                           push,
  output spat_pkg::cmd_t                 cmd
);

  logic                           is_local;
  logic [spat_pkg::SEL_W-1:0]     sel_ext;
  logic [spat_pkg::SEL_W-1:0]     idx_ext;
  logic [spat_pkg::SEL_W-1:0]     cnt_ext;
  logic [spat_pkg::SEL_W-1:0]     cnt_clamp;
  logic                           sel_bad;
  logic                           idx_ok;

  assign in_stall = busy || q_status.full;
  assign push     = in_valid && !in_stall;

  assign is_local  = in_item.segment_selector[2];
  assign sel_ext   = spat_pkg::SEL_W'(in_item.segment_selector[15:3]);
  assign idx_ext   = spat_pkg::SEL_W'(in_item.entry_index);
  assign cnt_ext   = spat_pkg::SEL_W'(is_local ? local_count : global_count);
  assign cnt_clamp = (cnt_ext > spat_pkg::DESC_DEPTH_C) ? spat_pkg::DESC_DEPTH_C : cnt_ext;
  assign sel_bad   = (sel_ext >= cnt_clamp) || (!is_local && sel_ext == '0);
  assign idx_ok    = idx_ext < spat_pkg::DESC_DEPTH_C;

  always_comb begin
    cmd.is_local       = is_local;
    cmd.entry_index    = in_item.entry_index;
    cmd.entry_data     = in_item.entry_data;
    cmd.logical_offset = in_item.logical_offset;
    cmd.desc_addr      = idx_ext[spat_pkg::DESC_AW-1:0];
    cmd.kind           = spat_pkg::K_NULL;
    unique case (in_item.opcode)
      spat_pkg::OP_TRANSLATE: begin
        cmd.desc_addr = sel_ext[spat_pkg::DESC_AW-1:0];
        cmd.kind      = sel_bad ? spat_pkg::K_SEL_FAULT : spat_pkg::K_TRANSLATE;
      end
      spat_pkg::OP_WR_GLOBAL: cmd.kind = idx_ok ? spat_pkg::K_WR_GLOBAL : spat_pkg::K_NULL;
      spat_pkg::OP_WR_LOCAL:  cmd.kind = idx_ok ? spat_pkg::K_WR_LOCAL : spat_pkg::K_NULL;
      spat_pkg::OP_WR_DIR:    cmd.kind = spat_pkg::K_WR_DIR;
      spat_pkg::OP_WR_PAGE:   cmd.kind = spat_pkg::K_WR_PAGE;
      default:                cmd.kind = spat_pkg::K_NULL;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/spat_queue.sv
`default_nettype none
module spat_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire spat_pkg::cmd_t      push_cmd,
  input  wire logic                pop,
  output spat_pkg::cmd_t           head,
  output spat_pkg::q_status_t      status
);

  spat_pkg::cmd_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    fill_nxt   = fill_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head         = slot_r[rd_ptr_r];
  assign status.valid = fill_r != 2'd0;
  assign status.full  = fill_r == 2'd2;

endmodule
`default_nettype wire

FILE: src/spat_back.sv
`default_nettype none
module spat_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire spat_pkg::q_status_t q_status,
  input  wire spat_pkg::cmd_t      head,
  output logic                     pop,
  output logic                     busy,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output spat_pkg::out_item_t      out_item
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_DESC  = 4'b0100,
    S_PAGE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [spat_pkg::DIR_AW-1:0] clr_idx_r, clr_idx_nxt;
  spat_pkg::cmd_t              cur_r, cur_nxt;
  logic [31:0]                 lin_r, lin_nxt;
  logic                        out_valid_r, out_valid_nxt;
  spat_pkg::out_item_t         out_r, out_nxt;

  logic                        out_free;
  logic                        load_out;
  spat_pkg::out_item_t         res;

  logic                        gd_we, ld_we, dir_we, pte_we;
  logic [63:0]                 gd_rd, ld_rd, desc;
  logic [0:0]                  dir_wdata, dir_rd;
  logic [20:0]                 pte_wdata, pte_rd;
  logic [spat_pkg::DIR_AW-1:0] pg_waddr;
  logic [19:0]                 limit20;
  logic [31:0]                 limit, base, lin;

  assign out_free = !out_valid_r || !out_stall;
  assign pop      = (state_r == S_IDLE) && q_status.valid && out_free;
  assign busy     = state_r == S_CLEAR;

  assign desc    = cur_r.is_local ? ld_rd : gd_rd;
  assign limit20 = {desc[51:48], desc[15:0]};
  assign limit   = desc[55] ? {limit20, 12'hFFF} : {12'd0, limit20};
  assign base    = {desc[63:56], desc[39:16]};
  assign lin     = base + cur_r.logical_offset;

  assign gd_we     = pop && head.kind == spat_pkg::K_WR_GLOBAL;
  assign ld_we     = pop && head.kind == spat_pkg::K_WR_LOCAL;
  assign dir_we    = busy || (pop && head.kind == spat_pkg::K_WR_DIR);
  assign pte_we    = busy || (pop && head.kind == spat_pkg::K_WR_PAGE);
  assign pg_waddr  = busy ? clr_idx_r : head.entry_index;
  assign dir_wdata = busy ? 1'b0 : head.entry_data[0];
  assign pte_wdata = busy ? 21'd0 : {head.entry_data[31:12], head.entry_data[0]};

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    cur_nxt     = cur_r;
    lin_nxt     = lin_r;
    load_out    = 1'b0;
    res         = '0;
    unique case (state_r)
      S_CLEAR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pop) begin
          cur_nxt = head;
          if (head.kind == spat_pkg::K_TRANSLATE) begin
            state_nxt = S_DESC;
          end else begin
            load_out = 1'b1;
            if (head.kind == spat_pkg::K_SEL_FAULT) begin
              res.fault_code = spat_pkg::FAULT_SEL;
            end
          end
        end
      end
      S_DESC: begin
        lin_nxt = lin;
        if (!desc[47]) begin
          load_out       = 1'b1;
          res.fault_code = spat_pkg::FAULT_SEG;
          state_nxt      = S_IDLE;
        end else if (cur_r.logical_offset > limit) begin
          load_out       = 1'b1;
          res.fault_code = spat_pkg::FAULT_LIMIT;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_PAGE;
        end
      end
      S_PAGE: begin
        load_out  = 1'b1;
        state_nxt = S_IDLE;
        if (!dir_rd[0] || !pte_rd[0]) begin
          res.fault_code = spat_pkg::FAULT_PAGE;
        end else begin
          res.fault_code       = spat_pkg::FAULT_OK;
          res.lin_addr         = lin_r;
          res.physical_address = {pte_rd[20:1], lin_r[11:0]};
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    lin_r <= lin_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  spat_ram #(.WIDTH(64), .DEPTH(spat_pkg::DESC_DEPTH)) u_gdt (
    .clk(clk), .we(gd_we), .waddr(head.desc_addr), .wdata(head.entry_data),
    .raddr(head.desc_addr), .rdata(gd_rd)
  );

  spat_ram #(.WIDTH(64), .DEPTH(spat_pkg::DESC_DEPTH)) u_ldt (
    .clk(clk), .we(ld_we), .waddr(head.desc_addr), .wdata(head.entry_data),
    .raddr(head.desc_addr), .rdata(ld_rd)
  );

  spat_ram #(.WIDTH(1), .DEPTH(spat_pkg::DIR_DEPTH)) u_dir (
    .clk(clk), .we(dir_we), .waddr(pg_waddr), .wdata(dir_wdata),
    .raddr(lin[31:22]), .rdata(dir_rd)
  );

  spat_ram #(.WIDTH(21), .DEPTH(spat_pkg::DIR_DEPTH)) u_pte (
    .clk(clk), .we(pte_we), .waddr(pg_waddr), .wdata(pte_wdata),
    .raddr(lin[21:12]), .rdata(pte_rd)
  );

endmodule
`default_nettype wire

FILE: src/spat_checker.sv
`default_nettype none
`include "assert_macros.svh"
module spat_props (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire spat_pkg::out_item_t out_item
);

  logic res_fault, res_ok, addr_zero, page_join;

  assign res_fault = out_valid && out_item.fault_code != spat_pkg::FAULT_OK;
  assign res_ok    = out_valid && out_item.fault_code == spat_pkg::FAULT_OK;
  assign addr_zero = out_item.lin_addr == 32'd0 && out_item.physical_address == 32'd0;
  assign page_join = out_item.physical_address[11:0] == out_item.lin_addr[11:0];

  // clearing pass follows every reset, input held off meanwhile
  `ASSERT_ALWAYS(a_reset_stall, clk, !rst_n |=> in_stall)
  `ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid)
  `ASSERT_RST(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid)
  `ASSERT_RST(a_fault_zero, clk, rst_n, res_fault |-> addr_zero)
  `ASSERT_RST(a_page_join, clk, rst_n, res_ok |-> page_join)

endmodule

bind segment_page_address_translator_unit spat_props u_spat_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
`default_nettype wire
